>>> rtl/core/htc_pkg.sv
`timescale 1ns / 1ps
package htc_pkg;

	typedef struct packed {
		logic [11:0][15:0] a;
		logic [3:0][31:0]  p;
	} vtx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_PSTART,
		S_PREV,
		S_RD,
		S_CUR,
		S_DEC,
		S_DIV,
		S_LERP,
		S_WCUR,
		S_ADV,
		S_PNEXT,
		S_EMCHK,
		S_EMRD,
		S_EMOUT
	} state_t;

	localparam int NUM_PLANES = 6;
	localparam logic [2:0] PLANE_LAST = 3'(NUM_PLANES - 1);
	// left, bottom, near test w + c; the others w - c
	localparam logic [5:0] PLANE_POS_MASK = 6'b011001;
	localparam logic [16:0] T_ONE = 17'h10000;
	localparam logic [2:0] MAX_TRIS = 3'd7;
	localparam logic [3:0] COMP_LAST = 4'd15;
	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_CLIP = 2'd2;
	localparam logic [1:0] CORNER_IGNORE = 2'd3;
	localparam logic [1:0] SLOT_LAST = 2'd2;

	function automatic logic signed [33:0] plane_dist(input vtx_t v, input logic [2:0] pl);
		logic [1:0]         axis;
		logic signed [33:0] c;
		logic signed [33:0] w;
		axis = pl[2:1];
		c = 34'(signed'(v.p[axis]));
		w = 34'(signed'(v.p[3]));
		plane_dist = PLANE_POS_MASK[pl] ? (w + c) : (w - c);
	endfunction

endpackage

>>> rtl/core/homogeneous_triangle_clipper.sv
`timescale 1ns / 1ps
// Clips one triangle against the six frustum planes and emits the result as a
// fan of triangles, one vertex per strobe on result_valid, last_vertex on the
// final one. Corners 0 and 1 are only latched; corner 2 starts a clip and
// holds busy high until the last vertex is out. Loading writes the three
// corners into the vertex buffer. Each plane pass reads every vertex, and
// each crossing runs a 16-step divider for the crossing factor, then one
// shared multiplier over 16 components, a multiply and a write phase for
// each, plus a write of the current vertex when the edge enters. Emission
// reads each vertex and then drives it. Results cannot be stalled: each is on
// the ports for exactly one cycle and must be taken then.
module homogeneous_triangle_clipper import htc_pkg::*; #(
	parameter int MAX_VERTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  corner,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] pos_w,
	input  logic [47:0] tex_coords,
	input  logic [47:0] colour_value,
	input  logic [47:0] normal_vec,
	input  logic [47:0] tangent_vec,
	output logic        result_valid,
	output logic [1:0]  out_corner,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_w,
	output logic [47:0] out_tex,
	output logic [47:0] out_colour,
	output logic [47:0] out_normal,
	output logic [47:0] out_tangent,
	output logic        last_vertex
);

	localparam int CW = $clog2(MAX_VERTS + 1);
	localparam int IW = $clog2(MAX_VERTS);
	localparam int AW = IW + 1;

	state_t state_q, state_d;

	vtx_t lat0_q, lat1_q, v2_q, prev_q, cur_q, in_v;
	logic          bank_q;
	logic [CW-1:0] n_q, m_q, i_q;
	logic [2:0]    plane_q;
	logic [1:0]    ld_q;
	logic          need_cur_q;
	logic [2:0]    tri_q, tris_q;
	logic [1:0]    slot_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	vtx_t          wdata, rdata;
	logic          div_start, div_done, lerp_start, lerp_done;
	logic [16:0]   t;
	vtx_t          lerp_r;

	logic signed [33:0] ds, de;
	logic signed [34:0] dd;
	logic [33:0]   num;
	logic [34:0]   den;
	logic          s_in, e_in, room, accept;
	logic [CW-1:0] n_m1, i_nx, nm2, em_idx;
	logic [2:0]    tris_d;
	logic          em_last;

	assign accept = start && !busy;
	assign in_v.p = {pos_w, pos_z, pos_y, pos_x};
	assign in_v.a = {tangent_vec, normal_vec, colour_value, tex_coords};

	always_comb begin
		ds = plane_dist(prev_q, plane_q);
		de = plane_dist(cur_q, plane_q);
		s_in = !ds[33];
		e_in = !de[33];
		dd = 35'(ds) - 35'(de);
		num = ds[33] ? 34'(-ds) : 34'(ds);
		den = dd[34] ? 35'(-dd) : 35'(dd);
		room = m_q < CW'(MAX_VERTS);
		n_m1 = n_q - CW'(1);
		i_nx = i_q + CW'(1);
		nm2 = n_q - CW'(2);
		tris_d = (nm2 > CW'(MAX_TRIS)) ? MAX_TRIS : nm2[2:0];
		em_idx = (slot_q == 2'd0) ? '0 : (CW'(tri_q) + CW'(slot_q));
		em_last = (slot_q == SLOT_LAST) && (tri_q == tris_q - 3'd1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept && corner == CORNER_CLIP) state_d = S_LOAD;
			S_LOAD:   if (ld_q == 2'd2) state_d = S_PSTART;
			S_PSTART: state_d = (n_q == '0) ? S_PNEXT : S_PREV;
			S_PREV:   state_d = S_RD;
			S_RD:     state_d = S_CUR;
			S_CUR:    state_d = S_DEC;
			S_DEC:    state_d = (s_in != e_in) ? S_DIV : S_ADV;
			S_DIV:    if (div_done) state_d = S_LERP;
			S_LERP:   if (lerp_done) state_d = need_cur_q ? S_WCUR : S_ADV;
			S_WCUR:   state_d = S_ADV;
			S_ADV:    state_d = (i_nx == n_q) ? S_PNEXT : S_RD;
			S_PNEXT:  state_d = (plane_q == PLANE_LAST) ? S_EMCHK : S_PSTART;
			S_EMCHK:  state_d = (n_q < CW'(3)) ? S_IDLE : S_EMRD;
			S_EMRD:   state_d = S_EMOUT;
			S_EMOUT:  state_d = em_last ? S_IDLE : S_EMRD;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = {~bank_q, m_q[IW-1:0]};
		wdata = cur_q;
		raddr = {bank_q, i_q[IW-1:0]};
		div_start = 1'b0;
		lerp_start = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				we = 1'b1;
				waddr = {1'b0, IW'(ld_q)};
				unique case (ld_q)
					2'd0:    wdata = lat0_q;
					2'd1:    wdata = lat1_q;
					default: wdata = v2_q;
				endcase
			end
			S_PSTART: raddr = {bank_q, n_m1[IW-1:0]};
			S_DEC: begin
				we = s_in && e_in && room;
				div_start = s_in != e_in;
			end
			S_DIV: lerp_start = div_done;
			S_LERP: begin
				we = lerp_done && room;
				wdata = lerp_r;
			end
			S_WCUR: we = room;
			S_EMRD: raddr = {bank_q, em_idx[IW-1:0]};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bank_q <= 1'b0;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			plane_q <= '0;
			ld_q <= '0;
			need_cur_q <= 1'b0;
			tri_q <= '0;
			tris_q <= '0;
			slot_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= state_q == S_EMOUT;
			if ((state_q == S_LOAD && ld_q == 2'd2) || (state_q == S_LERP && lerp_done)
				|| state_q == S_WCUR || (state_q == S_DEC && s_in && e_in)) begin
				if (room) m_q <= m_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					ld_q <= '0;
					bank_q <= 1'b0;
					plane_q <= '0;
				end
				S_LOAD: begin
					ld_q <= ld_q + 2'd1;
					n_q <= CW'(3);
				end
				S_PSTART: begin
					m_q <= '0;
					i_q <= '0;
				end
				S_DEC: need_cur_q <= !s_in && e_in;
				S_ADV: i_q <= i_nx;
				S_PNEXT: begin
					n_q <= m_q;
					bank_q <= ~bank_q;
					plane_q <= plane_q + 3'd1;
				end
				S_EMCHK: begin
					tris_q <= tris_d;
					tri_q <= '0;
					slot_q <= '0;
				end
				S_EMOUT: begin
					if (slot_q == SLOT_LAST) begin
						slot_q <= '0;
						tri_q <= tri_q + 3'd1;
					end else begin
						slot_q <= slot_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && corner == CORNER_FIRST) lat0_q <= in_v;
		if (accept && corner == CORNER_SECOND) lat1_q <= in_v;
		if (accept && corner == CORNER_CLIP) v2_q <= in_v;
		if (state_q == S_PREV || state_q == S_ADV) prev_q <= (state_q == S_ADV) ? cur_q : rdata;
		if (state_q == S_CUR) cur_q <= rdata;
		if (state_q == S_EMOUT) begin
			out_corner <= slot_q;
			out_x <= rdata.p[0];
			out_y <= rdata.p[1];
			out_z <= rdata.p[2];
			out_w <= rdata.p[3];
			out_tex <= {rdata.a[2], rdata.a[1], rdata.a[0]};
			out_colour <= {rdata.a[5], rdata.a[4], rdata.a[3]};
			out_normal <= {rdata.a[8], rdata.a[7], rdata.a[6]};
			out_tangent <= {rdata.a[11], rdata.a[10], rdata.a[9]};
			last_vertex <= em_last;
		end
	end

	assign busy = state_q != S_IDLE;

	htc_ram #(
		.WIDTH($bits(vtx_t)),
		.DEPTH(2 ** AW)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	htc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den),
		.t     (t),
		.done  (div_done)
	);

	htc_lerp u_lerp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.a     (prev_q),
		.b     (cur_q),
		.t     (t),
		.r     (lerp_r),
		.done  (lerp_done)
	);

endmodule

>>> rtl/core/htc_ram.sv
`timescale 1ns / 1ps
module htc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/htc_div.sv
`timescale 1ns / 1ps
module htc_div import htc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] num,
	input  logic [34:0] den,
	output logic [16:0] t,
	output logic        done
);

	logic [34:0] rem_q;
	logic [34:0] den_q;
	logic [15:0] quo_q;
	logic [16:0] t_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] rem2;
	logic        ge;
	logic [35:0] rem_sub;
	logic [15:0] quo_nx;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge = rem2 >= {1'b0, den_q};
		rem_sub = rem2 - {1'b0, den_q};
		quo_nx = {quo_q[14:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || {1'b0, num} >= den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= 5'd16;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
			if (den == '0) begin
				t_q <= '0;
			end else if ({1'b0, num} >= den) begin
				t_q <= T_ONE;
			end
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[34:0] : rem2[34:0];
			quo_q <= quo_nx;
			if (cnt_q == 5'd1) begin
				t_q <= {1'b0, quo_nx};
			end
		end
	end

	assign t = t_q;
	assign done = done_q;

endmodule

>>> rtl/core/htc_lerp.sv
`timescale 1ns / 1ps
module htc_lerp import htc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  vtx_t        a,
	input  vtx_t        b,
	input  logic [16:0] t,
	output vtx_t        r,
	output logic        done
);

	logic [3:0]         j_q;
	logic               ph_q;
	logic               run_q;
	logic               done_q;
	logic signed [50:0] prod_q;
	vtx_t               r_q;
	logic signed [32:0] ca;
	logic signed [32:0] cb;
	logic signed [32:0] diff;
	logic signed [17:0] ts;
	logic signed [50:0] prod;
	logic signed [50:0] rnd;
	logic signed [32:0] res;
	logic [3:0]         ai;

	always_comb begin
		ai = j_q - 4'd4;
		if (j_q < 4'd4) begin
			ca = 33'(signed'(a.p[j_q[1:0]]));
			cb = 33'(signed'(b.p[j_q[1:0]]));
		end else begin
			ca = 33'(signed'(a.a[ai]));
			cb = 33'(signed'(b.a[ai]));
		end
		diff = cb - ca;
		ts = signed'({1'b0, t});
		prod = diff * ts;
		rnd = prod_q + 51'sd32768;
		res = ca + 33'(rnd >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= 1'b0;
			j_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				ph_q <= 1'b0;
				j_q <= '0;
			end else if (run_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					j_q <= j_q + 4'd1;
					if (j_q == COMP_LAST) begin
						run_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			if (!ph_q) begin
				prod_q <= prod;
			end else if (j_q < 4'd4) begin
				r_q.p[j_q[1:0]] <= res[31:0];
			end else begin
				r_q.a[ai] <= res[15:0];
			end
		end
	end

	assign r = r_q;
	assign done = done_q;

endmodule

>>> rtl/core/htc_checker.sv
`timescale 1ns / 1ps
module htc_checker import htc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] corner,
	input logic       result_valid,
	input logic [1:0] out_corner,
	input logic       last_vertex
);

	a_latch_only: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && corner != CORNER_CLIP |=> !busy)
		else $error("busy after a corner that only latches");

	a_clip_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && corner == CORNER_CLIP |=> busy)
		else $error("clip item did not raise busy");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_vertex |-> busy)
		else $error("run ended without last_vertex");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_vertex |=> !result_valid)
		else $error("result after last_vertex");

	a_corner_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> out_corner != CORNER_IGNORE)
		else $error("bad out_corner");

endmodule

bind homogeneous_triangle_clipper htc_checker u_htc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.corner      (corner),
	.result_valid(result_valid),
	.out_corner  (out_corner),
	.last_vertex (last_vertex)
);
